### design/ise_pkg.sv
// shared types and constants for the indexed stack engine
`default_nettype none

package ise_pkg;

  localparam int ISE_DEPTH      = 1024;
  localparam int ISE_DATA_WIDTH = 32;

  // fixed field widths on the stream ports
  localparam int FUNC_W   = 4;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 11;
  localparam int STATUS_W = 2;
  localparam int S_DATA_W = 48;   // value + position, padded to bytes
  localparam int M_DATA_W = 72;   // data_out + position_out + match_count + fill_level

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH   = 4'd0,
    FN_POP    = 4'd1,
    FN_TOP    = 4'd2,
    FN_DROP   = 4'd3,
    FN_REMOVE = 4'd4,
    FN_READ   = 4'd5,
    FN_WRITE  = 4'd6,
    FN_FIND   = 4'd7,
    FN_COUNT  = 4'd8,
    FN_CLEAR  = 4'd9
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

endpackage

`default_nettype wire

### design/ise_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module ise_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/indexed_stack_engine_core.sv
// indexed stack engine: stack of signed words with access by position from the top
//
// One request goes in per transaction and one result comes out for each. The entries live in
// a single memory with one write and one registered read port; the engine walks it one entry
// per cycle. Push, clear, write-at and requests refused for an empty stack or a bad position
// skip the walk and go straight to the result; pop, top and read-at read one entry; count
// walks all held entries; find walks down from the top and stops at the first match, or walks
// every held entry when none matches; drop-bottom and remove-at move each entry above the
// removed one down a place, and skip the walk when nothing sits above the removed entry.
// The next request is taken once the current one has moved its result to the output
// register, even while that result still waits for the consumer. The memory holds no reset
// contents and needs no clearing pass; only entries below the fill level are ever read.
`default_nettype none

module indexed_stack_engine_core
  import ise_pkg::*;
#(
  parameter int DEPTH      = ISE_DEPTH,
  parameter int DATA_WIDTH = ISE_DATA_WIDTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [S_DATA_W-1:0] s_tdata,   // value[31:0], position[42:32], zero pad
  input  wire logic [FUNC_W-1:0]   s_tuser,   // func[3:0]
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [M_DATA_W-1:0]      m_tdata,   // data_out[31:0], position_out[42:32],
                                              // match_count[53:43], fill_level[64:54], zero pad
  output logic [STATUS_W-1:0]      m_tuser    // status[1:0]
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;

  logic [CW-1:0]         fill;
  func_t                 req_func;
  logic [DATA_WIDTH-1:0] req_val;

  status_t               res_status;
  logic [DATA_WIDTH-1:0] res_data;
  logic [POS_W-1:0]      res_pos;
  logic [CW-1:0]         res_cnt;

  status_t               out_status;
  logic [VALUE_W-1:0]    out_data;
  logic [POS_W-1:0]      out_pos;
  logic [POS_W-1:0]      out_cnt;
  logic [POS_W-1:0]      out_fill;

  // scan walker
  logic [AW-1:0] ptr;
  logic [AW-1:0] lim;
  logic [AW-1:0] paddr;
  logic          issue;
  logic          pend;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] mem_rdata;

  // request decode
  func_t                 in_func;
  logic [POS_W-1:0]      in_pos;
  logic [63:0]           in_val64;
  logic [DATA_WIDTH-1:0] in_val;
  logic [PW-1:0]         pos_w;
  logic [PW-1:0]         fill_w;
  logic                  in_range;
  logic [AW-1:0]         in_idx;
  logic [AW-1:0]         top_addr;
  logic                  is_full;
  logic                  is_empty;
  logic                  shift_op;
  logic [63:0]           res_data64;

  status_t               acc_status;
  logic [POS_W-1:0]      acc_pos;
  logic [CW-1:0]         fill_next;
  logic                  acc_scan;
  logic [AW-1:0]         acc_ptr;
  logic [AW-1:0]         acc_lim;
  logic                  find_hit;
  logic                  load_out;

  assign in_func  = func_t'(s_tuser);
  assign in_pos   = s_tdata[VALUE_W +: POS_W];
  assign in_val64 = 64'(signed'(s_tdata[VALUE_W-1:0]));
  assign in_val   = in_val64[DATA_WIDTH-1:0];
  assign pos_w    = PW'(in_pos);
  assign fill_w   = PW'(fill);
  assign in_range = (pos_w != '0) && (pos_w <= fill_w);
  assign in_idx   = AW'(fill_w - pos_w);
  assign top_addr = AW'(fill - CW'(1));
  assign is_full  = (fill == CW'(DEPTH));
  assign is_empty = (fill == '0);
  assign shift_op = (req_func == FN_DROP) || (req_func == FN_REMOVE);

  assign s_tready = (state == S_IDLE);

  assign find_hit = (state == S_SCAN) && pend && (req_func == FN_FIND) &&
                    (mem_rdata == req_val);
  assign load_out = (state == S_DONE) && (!m_tvalid || m_tready);

  // what an accepted request does to the fill level and whether it walks the memory
  always_comb begin
    acc_status = ST_OK;
    acc_pos    = '0;
    fill_next  = fill;
    acc_scan   = 1'b0;
    acc_ptr    = top_addr;
    acc_lim    = top_addr;
    if (in_func == FN_PUSH) begin
      if (is_full) begin
        acc_status = ST_FULL;
      end else begin
        fill_next = fill + CW'(1);
      end
    end else if (in_func == FN_CLEAR) begin
      fill_next = '0;
    end else if (is_empty && in_func inside {FN_POP, FN_TOP, FN_DROP, FN_REMOVE,
                                              FN_READ, FN_WRITE, FN_FIND, FN_COUNT}) begin
      acc_status = ST_EMPTY;
    end else begin
      case (in_func)
        FN_POP, FN_TOP: begin
          if (in_func == FN_POP) begin
            fill_next = fill - CW'(1);
          end
          acc_scan = 1'b1;
        end
        FN_DROP: begin
          fill_next = fill - CW'(1);
          acc_pos   = POS_W'(fill);
          acc_ptr   = AW'(1);
          acc_scan  = (top_addr != '0);
        end
        FN_REMOVE: begin
          if (!in_range) begin
            acc_status = ST_NOTFOUND;
          end else begin
            fill_next = fill - CW'(1);
            acc_pos   = in_pos;
            acc_ptr   = in_idx + AW'(1);
            acc_scan  = (in_idx != top_addr);
          end
        end
        FN_READ: begin
          if (!in_range) begin
            acc_status = ST_NOTFOUND;
          end else begin
            acc_pos  = in_pos;
            acc_ptr  = in_idx;
            acc_lim  = in_idx;
            acc_scan = 1'b1;
          end
        end
        FN_WRITE: begin
          if (!in_range) begin
            acc_status = ST_NOTFOUND;
          end else begin
            acc_pos = in_pos;
          end
        end
        FN_FIND: begin
          // walk from the top down so the first hit is the topmost
          acc_status = ST_NOTFOUND;
          acc_lim    = '0;
          acc_scan   = 1'b1;
        end
        FN_COUNT: begin
          acc_ptr  = '0;
          acc_scan = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(fill);
    mem_wdata = in_val;
    if (state == S_IDLE && s_tvalid) begin
      case (in_func)
        FN_PUSH: begin
          mem_we = !is_full;
        end
        FN_WRITE: begin
          mem_we    = !is_empty && in_range;
          mem_waddr = in_idx;
        end
        default: begin
        end
      endcase
    end else if (state == S_SCAN && pend && shift_op) begin
      // move the entry just read one place down
      mem_we    = 1'b1;
      mem_waddr = paddr - AW'(1);
      mem_wdata = mem_rdata;
    end
  end

  ise_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (ptr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fill     <= '0;
      m_tvalid <= 1'b0;
      issue    <= 1'b0;
      pend     <= 1'b0;
    end else begin
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req_func   <= in_func;
            req_val    <= in_val;
            res_status <= acc_status;
            res_data   <= '0;
            res_pos    <= acc_pos;
            res_cnt    <= '0;
            fill       <= fill_next;
            ptr        <= acc_ptr;
            lim        <= acc_lim;
            issue      <= acc_scan;
            state      <= acc_scan ? S_SCAN : S_DONE;
          end
        end
        S_SCAN: begin
          if (find_hit) begin
            res_status <= ST_OK;
            res_pos    <= POS_W'(fill - CW'(paddr));
            issue      <= 1'b0;
            pend       <= 1'b0;
            state      <= S_DONE;
          end else begin
            pend  <= issue;
            paddr <= ptr;
            if (issue) begin
              if (ptr == lim) begin
                issue <= 1'b0;
              end else if (req_func == FN_FIND) begin
                ptr <= ptr - AW'(1);
              end else begin
                ptr <= ptr + AW'(1);
              end
            end
            if (pend) begin
              case (req_func)
                FN_POP, FN_TOP, FN_READ: begin
                  res_data <= mem_rdata;
                end
                FN_COUNT: begin
                  if (mem_rdata == req_val) begin
                    res_cnt <= res_cnt + CW'(1);
                  end
                end
                default: begin
                end
              endcase
              if (!issue) begin
                state <= S_DONE;
              end
            end
          end
        end
        S_DONE: begin
          if (load_out) begin
            out_status <= res_status;
            out_data   <= res_data64[VALUE_W-1:0];
            out_pos    <= res_pos;
            out_cnt    <= POS_W'(res_cnt);
            out_fill   <= POS_W'(fill);
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res_data64 = 64'(signed'(res_data));

  assign m_tdata = {(M_DATA_W - VALUE_W - 3 * POS_W)'(0), out_fill, out_cnt, out_pos, out_data};
  assign m_tuser = out_status;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CW'(DEPTH))
    else $error("fill level above stack depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != S_IDLE))
    else $error("engine idle right after taking a request");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_DONE))
    else $error("result presented without finishing a request");

  a_shift_below_fill: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && mem_we) |-> (CW'(mem_waddr) < fill))
    else $error("shift write outside the held entries");

  a_scan_progress: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !issue && !pend) |-> 1'b0)
    else $error("scan stalled with nothing in flight");

endmodule

`default_nettype wire

### tb/tb_top.sv
// self-checking testbench for indexed_stack_engine_core: directed table, random mix, deep tail
`default_nettype none

module tb_top;
  import ise_pkg::*;

  typedef struct {
    status_t     status;
    logic [31:0] data;
    logic [10:0] pos_out;
    logic [10:0] match_cnt;
    logic [10:0] level;
  } stack_result_t;

  typedef struct {
    logic [3:0]    f;
    logic [31:0]   v;
    logic [10:0]   p;
    bit            typed;
    stack_result_t r;
  } plan_row_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [FUNC_W-1:0]   s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [STATUS_W-1:0] m_tuser;

  // shadow of the stack contents, entry 0 is the bottom
  logic [31:0]   held_words [ISE_DEPTH];
  int            held_count = 0;
  stack_result_t pending_results [$];
  int            errors = 0;
  bit            calm = 1'b0;

  logic [31:0] word_pool [4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};

  plan_row_t plan [26] = '{
    '{FN_POP,    32'h0,         11'd0,    1'b1, '{ST_EMPTY, 32'h0, 11'd0, 11'd0, 11'd0}},
    '{FN_TOP,    32'h0,         11'd0,    1'b1, '{ST_EMPTY, 32'h0, 11'd0, 11'd0, 11'd0}},
    '{FN_DROP,   32'h0,         11'd0,    1'b1, '{ST_EMPTY, 32'h0, 11'd0, 11'd0, 11'd0}},
    '{FN_FIND,   32'h0,         11'd0,    1'b1, '{ST_EMPTY, 32'h0, 11'd0, 11'd0, 11'd0}},
    '{FN_COUNT,  32'h0,         11'd0,    1'b1, '{ST_EMPTY, 32'h0, 11'd0, 11'd0, 11'd0}},
    '{FN_CLEAR,  32'h0,         11'd0,    1'b1, '{ST_OK, 32'h0, 11'd0, 11'd0, 11'd0}},
    '{FN_PUSH,   32'h7FFF_FFFF, 11'd0,    1'b1, '{ST_OK, 32'h0, 11'd0, 11'd0, 11'd1}},
    '{FN_PUSH,   32'h8000_0000, 11'd0,    1'b1, '{ST_OK, 32'h0, 11'd0, 11'd0, 11'd2}},
    '{FN_TOP,    32'h0,         11'd0,    1'b1, '{ST_OK, 32'h8000_0000, 11'd0, 11'd0, 11'd2}},
    '{FN_READ,   32'h0,         11'd2,    1'b1, '{ST_OK, 32'h7FFF_FFFF, 11'd2, 11'd0, 11'd2}},
    '{FN_READ,   32'h0,         11'd0,    1'b1, '{ST_NOTFOUND, 32'h0, 11'd0, 11'd0, 11'd2}},
    '{FN_READ,   32'h0,         11'd3,    1'b1, '{ST_NOTFOUND, 32'h0, 11'd0, 11'd0, 11'd2}},
    '{FN_REMOVE, 32'h0,         11'd2047, 1'b1, '{ST_NOTFOUND, 32'h0, 11'd0, 11'd0, 11'd2}},
    '{FN_WRITE,  32'hFFFF_FFFF, 11'd1,    1'b1, '{ST_OK, 32'h0, 11'd1, 11'd0, 11'd2}},
    '{FN_FIND,   32'hFFFF_FFFF, 11'd0,    1'b0, '{ST_OK, 32'h0, 11'd0, 11'd0, 11'd0}},
    '{FN_COUNT,  32'h7FFF_FFFF, 11'd0,    1'b0, '{ST_OK, 32'h0, 11'd0, 11'd0, 11'd0}},
    '{FN_COUNT,  32'h0,         11'd0,    1'b1, '{ST_OK, 32'h0, 11'd0, 11'd0, 11'd2}},
    '{FN_FIND,   32'h0000_0005, 11'd0,    1'b1, '{ST_NOTFOUND, 32'h0, 11'd0, 11'd0, 11'd2}},
    '{FN_PUSH,   32'h1234_5678, 11'd0,    1'b1, '{ST_OK, 32'h0, 11'd0, 11'd0, 11'd3}},
    '{FN_REMOVE, 32'h0,         11'd2,    1'b0, '{ST_OK, 32'h0, 11'd0, 11'd0, 11'd0}},
    '{FN_DROP,   32'h0,         11'd0,    1'b1, '{ST_OK, 32'h0, 11'd2, 11'd0, 11'd1}},
    '{4'd10,     32'hDEAD_BEEF, 11'd1,    1'b1, '{ST_OK, 32'h0, 11'd0, 11'd0, 11'd1}},
    '{4'd15,     32'hFFFF_FFFF, 11'd2047, 1'b1, '{ST_OK, 32'h0, 11'd0, 11'd0, 11'd1}},
    '{FN_POP,    32'h0,         11'd0,    1'b1, '{ST_OK, 32'h1234_5678, 11'd0, 11'd0, 11'd0}},
    '{FN_WRITE,  32'h0000_0003, 11'd1,    1'b1, '{ST_EMPTY, 32'h0, 11'd0, 11'd0, 11'd0}},
    '{FN_REMOVE, 32'h0,         11'd1,    1'b1, '{ST_EMPTY, 32'h0, 11'd0, 11'd0, 11'd0}}
  };

  indexed_stack_engine_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // applies one request to the shadow stack and returns what the engine should answer
  function automatic stack_result_t stack_request(logic [3:0] f, logic [31:0] v,
                                                  logic [10:0] p);
    stack_result_t r;
    int            n;
    int            idx;
    int            i;
    bit            pos_ok;
    r = '{ST_OK, 32'h0, 11'd0, 11'd0, 11'd0};
    n = held_count;
    pos_ok = (p >= 1) && (p <= n);
    idx = n - int'(p);
    if (f == FN_PUSH) begin
      if (n >= ISE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        held_words[n] = v;
        held_count = n + 1;
      end
    end else if (f == FN_CLEAR) begin
      held_count = 0;
    end else if (f <= FN_COUNT && n == 0) begin
      r.status = ST_EMPTY;
    end else begin
      case (f)
        FN_POP: begin
          r.data = held_words[n-1];
          held_count = n - 1;
        end
        FN_TOP: r.data = held_words[n-1];
        FN_DROP: begin
          for (i = 0; i + 1 < n; i++) held_words[i] = held_words[i+1];
          r.pos_out = 11'(n);
          held_count = n - 1;
        end
        FN_REMOVE, FN_READ, FN_WRITE: begin
          if (!pos_ok) begin
            r.status = ST_NOTFOUND;
          end else begin
            r.pos_out = p;
            if (f == FN_REMOVE) begin
              for (i = idx; i + 1 < n; i++) held_words[i] = held_words[i+1];
              held_count = n - 1;
            end else if (f == FN_READ) begin
              r.data = held_words[idx];
            end else begin
              held_words[idx] = v;
            end
          end
        end
        FN_FIND: begin
          r.status = ST_NOTFOUND;
          // topmost match wins
          for (i = 0; i < n; i++) begin
            if (held_words[n-1-i] == v) begin
              r.status = ST_OK;
              r.pos_out = 11'(i + 1);
              break;
            end
          end
        end
        FN_COUNT: begin
          for (i = 0; i < n; i++) if (held_words[i] == v) r.match_cnt++;
        end
        default: ;
      endcase
    end
    r.level = 11'(held_count);
    return r;
  endfunction

  task automatic send_item(input logic [3:0] f, input logic [31:0] v, input logic [10:0] p);
    while (!calm && $urandom_range(99) < 32) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {5'd0, p, v};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(stack_request(f, v, p));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 32);
    end
  end

  always @(posedge clk) begin : result_check
    stack_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected, status %0d", m_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(m_tuser));
        check_field("data_out", want.data, m_tdata[31:0]);
        check_field("position_out", 32'(want.pos_out), 32'(m_tdata[42:32]));
        check_field("match_count", 32'(want.match_cnt), 32'(m_tdata[53:43]));
        check_field("fill_level", 32'(want.level), 32'(m_tdata[64:54]));
      end
    end
  end

  initial begin
    int          k;
    int          j;
    int          roll;
    int          n;
    logic [3:0]  f;
    logic [31:0] v;
    logic [10:0] p;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (j = 0; j < 26; j++) begin
      send_item(plan[j].f, plan[j].v, plan[j].p);
      if (plan[j].typed) pending_results[pending_results.size()-1] = plan[j].r;
    end

    for (k = 0; k < 540; k++) begin
      calm = (k >= 230 && k < 330);
      if (k % 97 == 96) drain();
      n = held_count;
      roll = $urandom_range(99);
      if (n == 0 && roll < 70) f = FN_PUSH;
      else if (roll < 30) f = (n >= 60) ? FN_POP : FN_PUSH;
      else if (roll < 40) f = FN_POP;
      else if (roll < 46) f = FN_TOP;
      else if (roll < 51) f = FN_DROP;
      else if (roll < 59) f = FN_REMOVE;
      else if (roll < 67) f = FN_READ;
      else if (roll < 75) f = FN_WRITE;
      else if (roll < 84) f = FN_FIND;
      else if (roll < 93) f = FN_COUNT;
      else if (roll < 95) f = FN_CLEAR;
      else f = 4'($urandom_range(15, 10));
      // bias values toward words already held so find and count hit
      roll = $urandom_range(99);
      if (n != 0 && roll < 40) v = held_words[$urandom_range(n - 1)];
      else if (roll < 70) v = word_pool[$urandom_range(3)];
      else v = $urandom;
      roll = $urandom_range(99);
      if (n != 0 && roll < 75) p = 11'($urandom_range(n, 1));
      else if (roll < 88) p = roll[0] ? 11'd0 : 11'(n + 1);
      else p = 11'($urandom);
      send_item(f, v, p);
    end
    calm = 1'b0;

    // positions at and beyond the stack depth, then a few edge requests
    drain();
    send_item(FN_PUSH, 32'h0000_0005, 11'd0);
    send_item(FN_READ, 32'h0, 11'd1024);
    send_item(FN_READ, 32'h0, 11'd1025);
    send_item(FN_COUNT, word_pool[1], 11'd0);
    send_item(FN_FIND, held_words[0], 11'd0);
    send_item(FN_WRITE, 32'h5A5A_A5A5, 11'd1024);
    send_item(FN_REMOVE, 32'h0, 11'd1024);
    send_item(FN_PUSH, $urandom, 11'd0);
    send_item(FN_DROP, 32'h0, 11'd0);
    send_item(FN_TOP, 32'h0, 11'd0);
    send_item(FN_CLEAR, 32'h0, 11'd0);
    send_item(FN_POP, 32'h0, 11'd0);

    drain();
    repeat (1100) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

`default_nettype wire
